### rtl/core/stbr_pkg.sv
package stbr_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int BLK_W   = 32;
  localparam int LEN_W   = 16;
  localparam int COUNT_W = 17;

  localparam logic [BLK_W-1:0] MARK_AVAILABLE = 32'hFFFF_FFFF;
  localparam logic [BLK_W-1:0] MARK_DEFECTIVE = 32'hFFFF_FFF0;

  localparam logic [LEN_W-1:0] PACKET_LEN_RESET = 16'd32;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_XLATE = 2'd2
  } req_t;

  typedef enum logic {
    CFG_PACKET_LENGTH   = 1'b0,
    CFG_PARTITION_START = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BASE,
    ST_RD,
    ST_CHK
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BLK_W-1:0]  wr_original;
    logic [BLK_W-1:0]  wr_spared;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tbl_req_t;

endpackage

### rtl/core/sparing_table_block_remap_core.sv
// Sparing-table block remapper. A request is taken when start is high and busy is low;
// its single result appears for one cycle with done high and cannot be stalled.
// Clear, load and the unused request code keep busy low and done follows the accepting
// edge, so requests of that kind can be issued every cycle. A translate keeps busy high
// while the bit-serial remainder unit works (logical block mod packet length), then while
// the packet base is formed, then for a table read and a compare for each table entry
// examined. A walk ends on a hit or an available marker in the compare state, or in the
// table-read state once it has run to the end of the spared count. done is high in the
// first cycle with busy low again.
// spared_count and dead_count always show the current totals and are valid with done.
module sparing_table_block_remap_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   req_type,
  input  logic [stbr_pkg::BLK_W-1:0]   entry_original,
  input  logic [stbr_pkg::BLK_W-1:0]   entry_spared,
  input  logic [stbr_pkg::BLK_W-1:0]   logical_block,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [stbr_pkg::BLK_W-1:0]   cfg_wdata,
  output logic                         done,
  output logic [stbr_pkg::BLK_W-1:0]   physical_block,
  output logic                         was_remapped,
  output logic [stbr_pkg::COUNT_W-1:0] spared_count,
  output logic [stbr_pkg::COUNT_W-1:0] dead_count,
  output logic                         status
);
  import stbr_pkg::*;

  logic [LEN_W-1:0] packet_length;
  logic [BLK_W-1:0] partition_start;

  state_t           state, state_next;
  logic [CNT_W-1:0] fill_level, fill_level_next;
  logic [CNT_W-1:0] live_total, live_total_next;
  logic [CNT_W-1:0] defect_total, defect_total_next;
  logic             counting_stopped, counting_stopped_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [BLK_W-1:0] lblock, lblock_next;
  logic [LEN_W-1:0] offset, offset_next;
  logic [BLK_W-1:0] base, base_next;

  logic             done_next;
  logic [BLK_W-1:0] physical_block_next;
  logic             was_remapped_next;
  logic             status_next;

  logic             div_start;
  logic             div_done;
  logic [LEN_W-1:0] div_divisor;
  logic [LEN_W-1:0] div_rem;

  tbl_req_t         tbl_req;
  logic [BLK_W-1:0] rd_original;
  logic [BLK_W-1:0] rd_spared;

  logic             full;
  logic             hit;
  logic [BLK_W-1:0] add_a, add_b, add_sum;

  stbr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (logical_block),
    .divisor  (div_divisor),
    .done     (div_done),
    .remainder(div_rem)
  );

  stbr_table u_table (
    .clk        (clk),
    .req        (tbl_req),
    .rd_original(rd_original),
    .rd_spared  (rd_spared)
  );

  assign busy         = (state != ST_IDLE);
  assign spared_count = COUNT_W'(live_total);
  assign dead_count   = COUNT_W'(defect_total);
  assign full         = (fill_level == CNT_W'(TABLE_DEPTH));
  assign div_divisor  = (packet_length == '0) ? LEN_W'(1) : packet_length;
  assign hit          = (state == ST_CHK) && (rd_original == base);

  // one result adder: spared + offset on a hit, partition start + block otherwise
  assign add_a   = hit ? rd_spared : partition_start;
  assign add_b   = hit ? BLK_W'(offset) : lblock;
  assign add_sum = add_a + add_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_length   <= PACKET_LEN_RESET;
      partition_start <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_PACKET_LENGTH:   packet_length   <= cfg_wdata[LEN_W-1:0];
        CFG_PARTITION_START: partition_start <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      fill_level       <= '0;
      live_total       <= '0;
      defect_total     <= '0;
      counting_stopped <= 1'b0;
      done             <= 1'b0;
      was_remapped     <= 1'b0;
      status           <= 1'b0;
    end else begin
      state            <= state_next;
      fill_level       <= fill_level_next;
      live_total       <= live_total_next;
      defect_total     <= defect_total_next;
      counting_stopped <= counting_stopped_next;
      done             <= done_next;
      was_remapped     <= was_remapped_next;
      status           <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    idx            <= idx_next;
    lblock         <= lblock_next;
    offset         <= offset_next;
    base           <= base_next;
    physical_block <= physical_block_next;
  end

  always_comb begin
    state_next            = state;
    fill_level_next       = fill_level;
    live_total_next       = live_total;
    defect_total_next     = defect_total;
    counting_stopped_next = counting_stopped;
    idx_next              = idx;
    lblock_next           = lblock;
    offset_next           = offset;
    base_next             = base;
    done_next             = 1'b0;
    physical_block_next   = '0;
    was_remapped_next     = 1'b0;
    status_next           = 1'b0;
    div_start             = 1'b0;
    tbl_req.we            = 1'b0;
    tbl_req.waddr         = fill_level[ADDR_W-1:0];
    tbl_req.wr_original   = entry_original;
    tbl_req.wr_spared     = entry_spared;
    tbl_req.re            = 1'b0;
    tbl_req.raddr         = idx[ADDR_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (req_t'(req_type))
            REQ_CLEAR: begin
              fill_level_next       = '0;
              live_total_next       = '0;
              defect_total_next     = '0;
              counting_stopped_next = 1'b0;
              done_next             = 1'b1;
            end
            REQ_LOAD: begin
              done_next = 1'b1;
              if (full) begin
                status_next = 1'b1;
              end else begin
                tbl_req.we      = 1'b1;
                fill_level_next = fill_level + CNT_W'(1);
                if (!counting_stopped) begin
                  if (entry_original == MARK_AVAILABLE) begin
                    counting_stopped_next = 1'b1;
                  end else if (entry_original == MARK_DEFECTIVE) begin
                    defect_total_next = defect_total + CNT_W'(1);
                  end else begin
                    live_total_next = live_total + CNT_W'(1);
                  end
                end
              end
            end
            REQ_XLATE: begin
              lblock_next = logical_block;
              div_start   = 1'b1;
              state_next  = ST_DIV;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          offset_next = div_rem;
          state_next  = ST_BASE;
        end
      end
      ST_BASE: begin
        base_next  = lblock - BLK_W'(offset);
        idx_next   = '0;
        state_next = ST_RD;
      end
      ST_RD: begin
        if (idx < live_total) begin
          tbl_req.re = 1'b1;
          state_next = ST_CHK;
        end else begin
          physical_block_next = add_sum;
          done_next           = 1'b1;
          state_next          = ST_IDLE;
        end
      end
      ST_CHK: begin
        if (hit) begin
          physical_block_next = add_sum;
          was_remapped_next   = 1'b1;
          done_next           = 1'b1;
          state_next          = ST_IDLE;
        end else if (rd_original == MARK_AVAILABLE) begin
          physical_block_next = add_sum;
          done_next           = 1'b1;
          state_next          = ST_IDLE;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/stbr_div.sv
module stbr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [stbr_pkg::BLK_W-1:0] dividend,
  input  logic [stbr_pkg::LEN_W-1:0] divisor,
  output logic                      done,
  output logic [stbr_pkg::LEN_W-1:0] remainder
);
  import stbr_pkg::*;

  localparam int STEP_W = $clog2(BLK_W);

  logic              run;
  logic [STEP_W-1:0] step;
  logic [BLK_W-1:0]  dvd;
  logic [LEN_W-1:0]  dsr;
  logic [LEN_W:0]    shifted;
  logic              ge;
  logic [LEN_W-1:0]  rem_next;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    shifted  = {remainder, dvd[BLK_W-1]};
    ge       = (shifted >= {1'b0, dsr});
    rem_next = ge ? LEN_W'(shifted - {1'b0, dsr}) : shifted[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(BLK_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (run) begin
      dvd       <= dvd << 1;
      remainder <= rem_next;
    end
  end

endmodule

### rtl/core/stbr_table.sv
module stbr_table (
  input  logic                       clk,
  input  stbr_pkg::tbl_req_t         req,
  output logic [stbr_pkg::BLK_W-1:0] rd_original,
  output logic [stbr_pkg::BLK_W-1:0] rd_spared
);
  import stbr_pkg::*;

  logic [BLK_W-1:0] original_mem [TABLE_DEPTH];
  logic [BLK_W-1:0] spared_mem   [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      original_mem[req.waddr] <= req.wr_original;
      spared_mem[req.waddr]   <= req.wr_spared;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_original <= original_mem[req.raddr];
      rd_spared   <= spared_mem[req.raddr];
    end
  end

endmodule

### rtl/core/stbr_checker.sv
module stbr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   req_type,
  input logic                         done,
  input logic                         was_remapped,
  input logic [stbr_pkg::COUNT_W-1:0] spared_count,
  input logic [stbr_pkg::COUNT_W-1:0] dead_count,
  input logic                         status
);
  import stbr_pkg::*;

  // every finished request has busy low in its transfer cycle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted request");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_LOAD) |=> (done && !busy))
    else $error("load did not finish in one cycle");

  a_flags_with_done: assert property (@(posedge clk) disable iff (rst)
    (was_remapped || status) |-> (done && !(was_remapped && status)))
    else $error("result flag outside a transfer");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (spared_count + dead_count) <= COUNT_W'(TABLE_DEPTH))
    else $error("counts exceed table depth");

endmodule

bind sparing_table_block_remap_core stbr_checker u_stbr_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .req_type    (req_type),
  .done        (done),
  .was_remapped(was_remapped),
  .spared_count(spared_count),
  .dead_count  (dead_count),
  .status      (status)
);

### dv/tb_sparing_table_block_remap_core.sv
module tb_sparing_table_block_remap_core;
  import stbr_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  rq;
    logic [31:0] orig;
    logic [31:0] spare;
    logic [31:0] lb;
  } remap_req_t;

  typedef struct {
    bit [31:0] phys;
    bit        hit;
    bit [16:0] spared;
    bit [16:0] dead;
    bit        status;
  } remap_res_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [1:0]          req_type = REQ_CLEAR;
  logic [BLK_W-1:0]    entry_original = '0;
  logic [BLK_W-1:0]    entry_spared = '0;
  logic [BLK_W-1:0]    logical_block = '0;
  logic                cfg_we = 1'b0;
  logic                cfg_addr = CFG_PACKET_LENGTH;
  logic [BLK_W-1:0]    cfg_wdata = '0;
  logic                busy;
  logic                done;
  logic [BLK_W-1:0]    physical_block;
  logic                was_remapped;
  logic [COUNT_W-1:0]  spared_count;
  logic [COUNT_W-1:0]  dead_count;
  logic                status;

  sparing_table_block_remap_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .entry_original (entry_original),
    .entry_spared   (entry_spared),
    .logical_block  (logical_block),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .done           (done),
    .physical_block (physical_block),
    .was_remapped   (was_remapped),
    .spared_count   (spared_count),
    .dead_count     (dead_count),
    .status         (status)
  );

  always #5 clk = ~clk;

  // predictor copy of the block state
  bit [31:0] orig_mem [TABLE_DEPTH];
  bit [31:0] dest_mem [TABLE_DEPTH];
  int        fill_cnt;
  int        live_cnt;
  int        dead_cnt;
  bit        count_frozen;
  bit [15:0] pkt_len_reg = PACKET_LEN_RESET;
  bit [31:0] part_start_reg = '0;

  remap_req_t pend_q[$];
  remap_res_t result_q[$];
  remap_req_t nxt;
  logic       start_taken = 1'b0;
  bit         steady = 1'b0;

  int errors;
  int n_checked;
  int n_xlate;
  int n_hits;
  int n_settings;

  function automatic bit [31:0] eff_len();
    return (pkt_len_reg == 0) ? 32'd1 : {16'd0, pkt_len_reg};
  endfunction

  function automatic bit [31:0] packet_base(bit [31:0] lb);
    return lb - (lb % eff_len());
  endfunction

  function automatic remap_res_t apply_request(logic [1:0] rq, logic [31:0] orig,
                                               logic [31:0] spare, logic [31:0] lb);
    remap_res_t r;
    bit [31:0]  ofs;
    bit [31:0]  base;
    int         i;
    r = '{default: 0};
    case (rq)
      REQ_CLEAR: begin
        fill_cnt = 0;
        live_cnt = 0;
        dead_cnt = 0;
        count_frozen = 0;
      end
      REQ_LOAD: begin
        if (fill_cnt >= TABLE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          orig_mem[fill_cnt] = orig;
          dest_mem[fill_cnt] = spare;
          fill_cnt++;
          if (!count_frozen) begin
            if (orig == MARK_AVAILABLE) count_frozen = 1'b1;
            else if (orig == MARK_DEFECTIVE) dead_cnt++;
            else live_cnt++;
          end
        end
      end
      REQ_XLATE: begin
        ofs = lb % eff_len();
        base = lb - ofs;
        r.phys = base + part_start_reg;
        for (i = 0; i < live_cnt; i++) begin
          if (orig_mem[i] == base) begin
            r.phys = dest_mem[i];
            r.hit = 1'b1;
            break;
          end
          if (orig_mem[i] == MARK_AVAILABLE) break;
        end
        r.phys = r.phys + ofs;
      end
      default: ;
    endcase
    r.spared = 17'(live_cnt);
    r.dead = 17'(dead_cnt);
    return r;
  endfunction

  function automatic void check_field(string name, bit [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      errors++;
    end
  endfunction

  // driver: a held request moves on only after its transfer
  always @(negedge clk) begin
    if (!rst && (!start || start_taken)) begin
      if (pend_q.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
        nxt = pend_q.pop_front();
        start <= 1'b1;
        req_type <= nxt.rq;
        entry_original <= nxt.orig;
        entry_spared <= nxt.spare;
        logical_block <= nxt.lb;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the result first, then record a new transfer
  always @(posedge clk) begin
    remap_res_t want;
    if (rst) begin
      start_taken <= 1'b0;
    end else begin
      if (done === 1'b1) begin
        if (result_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = result_q.pop_front();
          n_checked++;
          check_field("physical_block", want.phys, physical_block);
          check_field("was_remapped", 32'(want.hit), 32'(was_remapped));
          check_field("spared_count", 32'(want.spared), 32'(spared_count));
          check_field("dead_count", 32'(want.dead), 32'(dead_count));
          check_field("status", 32'(want.status), 32'(status));
        end
      end
      start_taken <= start && !busy;
      if (start && busy === 1'b0) begin
        want = apply_request(req_type, entry_original, entry_spared, logical_block);
        if (req_type == REQ_XLATE) n_xlate++;
        if (want.hit) n_hits++;
        result_q.push_back(want);
      end
    end
  end

  task automatic queue_req(logic [1:0] rq, logic [31:0] orig, logic [31:0] spare,
                           logic [31:0] lb);
    remap_req_t it;
    it = '{rq, orig, spare, lb};
    pend_q.push_back(it);
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || result_q.size() != 0 || start) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == CFG_PACKET_LENGTH) pkt_len_reg = val[15:0];
    else part_start_reg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] len, logic [31:0] pstart);
    drain();
    write_reg(CFG_PACKET_LENGTH, len);
    write_reg(CFG_PARTITION_START, pstart);
    n_settings++;
  endtask

  // mostly clear/load/translate sequences with random content, some noise
  task automatic run_mix(int n_items);
    bit [31:0] bases[$];
    int        pushed;
    int        nload;
    int        ntr;
    int        kind;
    bit [31:0] o;
    bit [31:0] lb;
    pushed = 0;
    while (pushed < n_items) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(9) != 0) begin
          queue_req(REQ_CLEAR, $urandom(), $urandom(), $urandom());
          pushed++;
          bases.delete();
        end
        nload = $urandom_range(10);
        repeat (nload) begin
          kind = $urandom_range(19);
          if (kind == 0) o = MARK_AVAILABLE;
          else if (kind <= 2) o = MARK_DEFECTIVE;
          else if (kind == 3 && bases.size() != 0) o = bases[$urandom_range(bases.size() - 1)];
          else o = packet_base($urandom());
          if (o != MARK_AVAILABLE && o != MARK_DEFECTIVE) bases.push_back(o);
          queue_req(REQ_LOAD, o, $urandom(), $urandom());
          pushed++;
        end
        ntr = $urandom_range(1, 8);
        repeat (ntr) begin
          if (bases.size() != 0 && $urandom_range(9) < 7)
            lb = bases[$urandom_range(bases.size() - 1)] + ($urandom() % eff_len());
          else
            lb = $urandom();
          queue_req(REQ_XLATE, $urandom(), $urandom(), lb);
          pushed++;
        end
      end else begin
        kind = $urandom_range(3);
        queue_req((kind == 0) ? REQ_UNUSED : (kind == 1) ? REQ_LOAD : REQ_XLATE,
                  $urandom(), $urandom(), $urandom());
        pushed++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset register values: packet length 32, partition start 0
    queue_req(REQ_XLATE, '0, '0, 32'h0000_0045);
    queue_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(REQ_LOAD, 32'h0000_0040, 32'h0000_1000, '0);
    queue_req(REQ_LOAD, 32'hFFFF_FFE0, 32'hFFFF_FFF0, '0);
    queue_req(REQ_LOAD, MARK_DEFECTIVE, 32'h0000_5000, '0);
    queue_req(REQ_XLATE, '0, '0, 32'h0000_0041);
    queue_req(REQ_XLATE, '0, '0, 32'hFFFF_FFFF);     // spared + offset wraps
    queue_req(REQ_XLATE, '0, '0, 32'h0000_0080);
    queue_req(REQ_LOAD, MARK_AVAILABLE, 32'h1234_5678, '0);
    queue_req(REQ_LOAD, 32'h0000_0080, 32'h0000_2000, '0);  // stored, not counted
    queue_req(REQ_LOAD, MARK_DEFECTIVE, 32'h0000_3000, '0);
    queue_req(REQ_XLATE, '0, '0, 32'h0000_0085);
    queue_req(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(REQ_XLATE, '0, '0, 32'h0000_0041);
    queue_req(REQ_LOAD, MARK_AVAILABLE, '0, '0);
    queue_req(REQ_LOAD, 32'h0000_0000, 32'h0000_7000, '0);
    queue_req(REQ_XLATE, '0, '0, 32'h0000_0003);
    queue_req(REQ_CLEAR, '0, '0, '0);

    set_regs(32'd1, 32'hFFFF_FFFF);
    run_mix(75);
    set_regs(32'd0, $urandom());   // zero length acts as one
    run_mix(75);
    set_regs(32'd65535, 32'h8000_0000);
    run_mix(75);

    // a defective marker entry inside the searched range can still match
    set_regs(32'd16, 32'd0);
    queue_req(REQ_CLEAR, '0, '0, '0);
    queue_req(REQ_LOAD, MARK_DEFECTIVE, 32'h0000_9000, '0);
    queue_req(REQ_LOAD, 32'h0000_0100, 32'h0000_A000, '0);
    queue_req(REQ_XLATE, '0, '0, 32'hFFFF_FFF7);
    queue_req(REQ_XLATE, '0, '0, 32'h0000_010F);
    run_mix(75);

    set_regs(32'd7, $urandom());
    steady = 1'b1;
    run_mix(75);
    drain();
    steady = 1'b0;
    set_regs($urandom_range(1, 65535), $urandom());
    run_mix(75);
    drain();
    repeat (40) @(posedge clk);

    $display("Checked %0d results: %0d translates, %0d of them remapped",
             n_checked, n_xlate, n_hits);
    $display("Register settings exercised: %0d besides the reset values", n_settings);
    if (errors == 0 && result_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d results still outstanding", result_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
